// File: src/npcs_pkg.sv
// Package for the nearest palette colour search: widths, codes, types and
// the two distance term tables, built exactly with integers at elaboration.
// Depends on nothing; every other file of the block refers to it.
`timescale 1ns / 1ps

package npcs_pkg;

   // Palette geometry
   localparam int PAL_ENTRIES = 16;
   localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
   localparam int SIZE_W      = 5;
   localparam int CHAN_W      = 8;
   localparam int DIST_W      = 16;
   localparam int TERM_DEPTH  = 256;

   // Channel weights of the distance
   localparam int WEIGHT_RB = 8;
   localparam int WEIGHT_G  = 11;

   // Reset value of the palette size register
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(PAL_ENTRIES);

   // Operation codes of a request beat
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   // One palette colour
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   // Tag that travels with each entry through the scan pipeline
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [PAL_IDX_W-1:0] index;
   } tag_type;

   typedef logic [DIST_W-1:0] term_table_type [TERM_DEPTH];

   // Round-half-up of 256*(dw/255)^1.8: the largest v with v == 0 or
   // (2v-1)^5 * 255^9 <= 512^5 * dw^9, found by a binary search.
   function automatic logic [DIST_W-1:0] term_value(input int unsigned dw);
      logic [191:0] lhs;
      logic [191:0] rhs;
      logic [191:0] odd;
      logic [16:0]  lo;
      logic [16:0]  hi;
      logic [16:0]  mid;
      lo = '0;
      hi = 17'd65535;
      for (int s = 0; s < 17; s++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 17'd1) >> 1);
            odd = (192'(mid) << 1) - 192'd1;
            lhs = 192'd1;
            rhs = 192'd1;
            for (int i = 0; i < 5; i++) begin
               lhs = lhs * odd;
               rhs = rhs * 192'd512;
            end
            for (int i = 0; i < 9; i++) begin
               lhs = lhs * 192'd255;
               rhs = rhs * 192'(dw);
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 17'd1;
            end
         end
      end
      return lo[DIST_W-1:0];
   endfunction

   function automatic term_table_type build_term_table(input int unsigned weight);
      term_table_type t;
      for (int d = 0; d < TERM_DEPTH; d++) begin
         t[d] = term_value(d * weight);
      end
      return t;
   endfunction

   localparam term_table_type TERM_RB = build_term_table(WEIGHT_RB);
   localparam term_table_type TERM_G  = build_term_table(WEIGHT_G);

endpackage

// File: src/npcs_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on npcs_pkg for the field widths.
`timescale 1ns / 1ps

interface npcs_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [npcs_pkg::PAL_IDX_W-1:0] entry_index;
   logic [npcs_pkg::CHAN_W-1:0]    red;
   logic [npcs_pkg::CHAN_W-1:0]    green;
   logic [npcs_pkg::CHAN_W-1:0]    blue;

   modport source (output valid, operation, entry_index, red, green, blue, input ready);
   modport sink   (input valid, operation, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [npcs_pkg::PAL_IDX_W-1:0] best_index;
   logic [npcs_pkg::CHAN_W-1:0]    best_red;
   logic [npcs_pkg::CHAN_W-1:0]    best_green;
   logic [npcs_pkg::CHAN_W-1:0]    best_blue;
   logic [npcs_pkg::DIST_W-1:0]    best_distance;

   modport source (output valid, best_index, best_red, best_green, best_blue, best_distance,
                   input ready);
   modport sink   (input valid, best_index, best_red, best_green, best_blue, best_distance,
                   output ready);
endinterface

// File: src/npcs_palette_ram.sv
// Palette store: one write port, one read port with registered read data.
// Depends on npcs_pkg for the entry type and depth.
`timescale 1ns / 1ps

module npcs_palette_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [npcs_pkg::PAL_IDX_W-1:0] wr_addr,
   input  npcs_pkg::rgb_type              wr_data,
   input  logic                           rd_en,
   input  logic [npcs_pkg::PAL_IDX_W-1:0] rd_addr,
   output npcs_pkg::rgb_type              rd_data
);

   npcs_pkg::rgb_type mem_ff [npcs_pkg::PAL_ENTRIES];
   npcs_pkg::rgb_type rd_data_ff;

   // Store a written entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/npcs_dist_unit.sv
// Shared distance unit: absolute channel differences, table terms and their
// sum, registered together with the entry's tag and colour.
// Depends on npcs_pkg for the term tables and types.
`timescale 1ns / 1ps

module npcs_dist_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  npcs_pkg::rgb_type           pixel,
   input  npcs_pkg::rgb_type           entry,
   input  npcs_pkg::tag_type           tag_in,
   output npcs_pkg::rgb_type           entry_out,
   output npcs_pkg::tag_type           tag_out,
   output logic [npcs_pkg::DIST_W-1:0] dist_out
);

   logic [npcs_pkg::CHAN_W-1:0] diff_red;
   logic [npcs_pkg::CHAN_W-1:0] diff_green;
   logic [npcs_pkg::CHAN_W-1:0] diff_blue;
   logic [npcs_pkg::DIST_W-1:0] dist_in;

   logic                        valid_ff;
   logic                        last_ff;
   logic [npcs_pkg::PAL_IDX_W-1:0] index_ff;
   npcs_pkg::rgb_type           entry_ff;
   logic [npcs_pkg::DIST_W-1:0] dist_ff;

   // Take absolute differences per channel
   assign diff_red   = (entry.red > pixel.red) ? entry.red - pixel.red
                                               : pixel.red - entry.red;
   assign diff_green = (entry.green > pixel.green) ? entry.green - pixel.green
                                                   : pixel.green - entry.green;
   assign diff_blue  = (entry.blue > pixel.blue) ? entry.blue - pixel.blue
                                                 : pixel.blue - entry.blue;

   // Sum the weighted terms; the largest sum stays below 2^16
   assign dist_in = npcs_pkg::TERM_RB[diff_red] + npcs_pkg::TERM_G[diff_green]
                  + npcs_pkg::TERM_RB[diff_blue];

   // Hold the stage valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag_in.valid;
      end
   end

   // Register the payload of the stage
   always_ff @(posedge clock) begin
      if (tag_in.valid) begin
         last_ff  <= tag_in.last;
         index_ff <= tag_in.index;
         entry_ff <= entry;
         dist_ff  <= dist_in;
      end
   end

   assign tag_out   = '{valid: valid_ff, last: last_ff, index: index_ff};
   assign entry_out = entry_ff;
   assign dist_out  = dist_ff;

endmodule

// File: src/nearest_palette_color_search.sv
// Top level of the nearest palette colour search: controller, scan pipeline
// and response register. Depends on npcs_pkg, npcs_if, npcs_palette_ram and
// npcs_dist_unit.
//
//   channel  | direction | beat
//   ---------+-----------+---------------------------------------------------
//   req_if   | in        | operation, entry_index, red, green, blue
//   rsp_if   | out       | best_index, best_red, best_green, best_blue, best_distance
//   csr_*    | in        | palette size, written whenever csr_wr_en is high
//
// A write beat is stored when accepted. A query scans entries 0 to n-1, n being
// the clamped palette size: the RAM read port delivers one entry per cycle, and
// each passes the RAM read stage and the distance stage into the best register;
// the result load waits until the response register is free. One item is in
// flight at a time; a new request is accepted while an earlier response still waits.
// Reset is synchronous: it clears the controller and the response valid and sets
// the size register to PAL_ENTRIES; palette contents are undefined until written.
`timescale 1ns / 1ps

module nearest_palette_color_search (
   input  logic                          clock,
   input  logic                          reset,
   npcs_req_if.sink                      req_if,
   npcs_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [npcs_pkg::SIZE_W-1:0]   csr_wr_data
);

   npcs_pkg::state_type state_ff;
   npcs_pkg::state_type state_in;

   logic [npcs_pkg::SIZE_W-1:0]    size_ff;
   logic [npcs_pkg::PAL_IDX_W-1:0] last_idx;
   logic [npcs_pkg::PAL_IDX_W-1:0] last_ff;
   logic [npcs_pkg::PAL_IDX_W-1:0] scan_cnt_ff;
   logic [npcs_pkg::PAL_IDX_W-1:0] scan_cnt_in;
   npcs_pkg::rgb_type              pixel_ff;

   logic req_accept;
   logic query_accept;
   logic write_accept;
   logic issue;
   logic rsp_load;

   npcs_pkg::tag_type              ram_tag_ff;
   npcs_pkg::tag_type              ram_tag;
   npcs_pkg::rgb_type              ram_data;
   npcs_pkg::rgb_type              dist_entry;
   npcs_pkg::tag_type              dist_tag;
   logic [npcs_pkg::DIST_W-1:0]    dist_value;

   logic                           take_best;
   logic [npcs_pkg::PAL_IDX_W-1:0] best_index_ff;
   npcs_pkg::rgb_type              best_rgb_ff;
   logic [npcs_pkg::DIST_W-1:0]    best_dist_ff;

   logic                           rsp_valid_ff;
   logic [npcs_pkg::PAL_IDX_W-1:0] rsp_index_ff;
   npcs_pkg::rgb_type              rsp_rgb_ff;
   logic [npcs_pkg::DIST_W-1:0]    rsp_dist_ff;

   // Hold the palette size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= npcs_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // Clamp the size to 1..PAL_ENTRIES and give the last entry scanned
   always_comb begin
      if (size_ff == '0) begin
         last_idx = '0;
      end else if (size_ff > npcs_pkg::SIZE_W'(npcs_pkg::PAL_ENTRIES)) begin
         last_idx = npcs_pkg::PAL_IDX_W'(npcs_pkg::PAL_ENTRIES - 1);
      end else begin
         last_idx = npcs_pkg::PAL_IDX_W'(size_ff - npcs_pkg::SIZE_W'(1));
      end
   end

   assign req_accept   = req_if.valid && req_if.ready;
   assign query_accept = req_accept && (req_if.operation == npcs_pkg::OP_QUERY);
   assign write_accept = req_accept && (req_if.operation == npcs_pkg::OP_WRITE);

   // Controller state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= npcs_pkg::ST_IDLE;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   // Next state and controller outputs
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      req_if.ready = 1'b0;
      issue        = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         npcs_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            scan_cnt_in  = '0;
            if (query_accept) begin
               state_in = npcs_pkg::ST_SCAN;
            end
         end
         npcs_pkg::ST_SCAN: begin
            issue = 1'b1;
            if (scan_cnt_ff == last_ff) begin
               state_in = npcs_pkg::ST_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + npcs_pkg::PAL_IDX_W'(1);
            end
         end
         npcs_pkg::ST_DRAIN: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = npcs_pkg::ST_RESULT;
            end
         end
         npcs_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Latch the pixel and the scan length of a query
   always_ff @(posedge clock) begin
      if (query_accept) begin
         pixel_ff <= '{red: req_if.red, green: req_if.green, blue: req_if.blue};
         last_ff  <= last_idx;
      end
   end

   npcs_palette_ram u_ram (
      .clock   (clock),
      .wr_en   (write_accept),
      .wr_addr (req_if.entry_index),
      .wr_data ('{red: req_if.red, green: req_if.green, blue: req_if.blue}),
      .rd_en   (issue),
      .rd_addr (scan_cnt_ff),
      .rd_data (ram_data)
   );

   // Tag the entry in the RAM read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_tag_ff <= '0;
      end else begin
         ram_tag_ff <= '{valid: issue, last: (scan_cnt_ff == last_ff), index: scan_cnt_ff};
      end
   end

   assign ram_tag = ram_tag_ff;

   npcs_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .pixel     (pixel_ff),
      .entry     (ram_data),
      .tag_in    (ram_tag),
      .entry_out (dist_entry),
      .tag_out   (dist_tag),
      .dist_out  (dist_value)
   );

   // Keep the first entry, replace it only on a strictly smaller distance
   assign take_best = dist_tag.valid &&
                      ((dist_tag.index == '0) || (dist_value < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_index_ff <= dist_tag.index;
         best_rgb_ff   <= dist_entry;
         best_dist_ff  <= dist_value;
      end
   end

   // Response register: load the result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= best_index_ff;
         rsp_rgb_ff   <= best_rgb_ff;
         rsp_dist_ff  <= best_dist_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.best_index    = rsp_index_ff;
   assign rsp_if.best_red      = rsp_rgb_ff.red;
   assign rsp_if.best_green    = rsp_rgb_ff.green;
   assign rsp_if.best_blue     = rsp_rgb_ff.blue;
   assign rsp_if.best_distance = rsp_dist_ff;

   // The scan counter never passes the last entry of the query
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == npcs_pkg::ST_SCAN) |-> (scan_cnt_ff <= last_ff))
      else $error("scan counter beyond the last palette entry");

   // At most one last-tagged entry is in flight
   a_one_last: assert property (@(posedge clock) disable iff (reset)
      $countones({ram_tag_ff.valid && ram_tag_ff.last,
                  dist_tag.valid && dist_tag.last}) <= 1)
      else $error("more than one last entry in the scan pipeline");

   // The pipeline is empty once the result is ready to load
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == npcs_pkg::ST_RESULT) |-> (!ram_tag_ff.valid && !dist_tag.valid))
      else $error("scan pipeline busy while the result is loaded");

   // A loaded result names an entry inside the scanned range
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_index_ff <= last_ff))
      else $error("best index outside the scanned range");

endmodule

// File: tb/npcs_search_checker.sv
// Checker for the nearest palette colour search: watches the request, response
// and size register ports, predicts each query result and compares it.
// Depends on npcs_pkg and the channel interfaces in npcs_if.
`timescale 1ns / 1ps

module npcs_search_checker
   import npcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   npcs_req_if               req_mon,
   npcs_rsp_if               rsp_mon,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   output int                mismatch_count,
   output int                pending_count,
   output int                query_count,
   output int                answer_count
);

   typedef struct packed {
      logic [PAL_IDX_W-1:0] index;
      rgb_type              color;
      logic [DIST_W-1:0]    distance;
   } nearest_type;

   // Shadow copy of the palette, the size register and the distance terms
   rgb_type           swatch [PAL_ENTRIES];
   logic [SIZE_W-1:0] size_reg = SIZE_RESET;
   logic [DIST_W-1:0] term_rb [TERM_DEPTH];
   logic [DIST_W-1:0] term_g  [TERM_DEPTH];

   nearest_type nearest_q [$];
   int          bad_total;
   int          query_total;
   int          answer_total;

   // True when (2v-1)^5 * 255^9 <= 512^5 * dw^9, for v >= 1
   function automatic bit term_fits(input int unsigned v, input int unsigned dw);
      logic [191:0] lhs;
      logic [191:0] rhs;
      lhs = 192'd1;
      rhs = 192'd1;
      for (int i = 0; i < 5; i++) begin
         lhs = lhs * 192'(2 * v - 1);
         rhs = rhs << 9;
      end
      for (int i = 0; i < 9; i++) begin
         lhs = lhs * 192'd255;
         rhs = rhs * 192'(dw);
      end
      return lhs <= rhs;
   endfunction

   // Start from a real-valued estimate, then settle on the exact rounded value
   function automatic logic [DIST_W-1:0] rounded_term(input int unsigned dw);
      real         ratio;
      int unsigned v;
      ratio = dw / 255.0;
      v = $rtoi(256.0 * (ratio ** 1.8) + 0.5);
      if (v > 65535) v = 65535;
      while (v < 65535 && term_fits(v + 1, dw)) v++;
      while (v > 0 && !term_fits(v, dw)) v--;
      return DIST_W'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] chan_gap(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Scan the searched entries; a strictly smaller distance takes over
   function automatic nearest_type nearest_entry(input rgb_type pixel);
      nearest_type best;
      int unsigned span;
      int unsigned total;
      span = size_reg;
      if (span == 0) span = 1;
      if (span > PAL_ENTRIES) span = PAL_ENTRIES;
      best = '0;
      for (int i = 0; i < span; i++) begin
         total = term_rb[chan_gap(swatch[i].red, pixel.red)]
               + term_g[chan_gap(swatch[i].green, pixel.green)]
               + term_rb[chan_gap(swatch[i].blue, pixel.blue)];
         if (i == 0 || total < best.distance) begin
            best.index    = PAL_IDX_W'(i);
            best.color    = swatch[i];
            best.distance = DIST_W'(total);
         end
      end
      return best;
   endfunction

   initial begin
      for (int d = 0; d < TERM_DEPTH; d++) begin
         term_rb[d] = rounded_term(d * WEIGHT_RB);
         term_g[d]  = rounded_term(d * WEIGHT_G);
      end
   end

   always @(posedge clock) begin : watch
      nearest_type want;
      rgb_type     pixel;
      int          bad;
      bad = 0;
      if (reset) begin
         nearest_q.delete();
         size_reg = SIZE_RESET;
      end else begin
         if (csr_wr_en) size_reg = csr_wr_data;

         // Compare a response beat with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            answer_total++;
            if (nearest_q.size() == 0) begin
               $error("response beat with no query waiting: best_index %0d",
                      rsp_mon.best_index);
               bad++;
            end else begin
               want = nearest_q.pop_front();
               if (rsp_mon.best_index !== want.index) begin
                  $error("best_index mismatch: expected %0d, actual %0d",
                         want.index, rsp_mon.best_index);
                  bad++;
               end
               if (rsp_mon.best_red !== want.color.red) begin
                  $error("best_red mismatch: expected %0d, actual %0d",
                         want.color.red, rsp_mon.best_red);
                  bad++;
               end
               if (rsp_mon.best_green !== want.color.green) begin
                  $error("best_green mismatch: expected %0d, actual %0d",
                         want.color.green, rsp_mon.best_green);
                  bad++;
               end
               if (rsp_mon.best_blue !== want.color.blue) begin
                  $error("best_blue mismatch: expected %0d, actual %0d",
                         want.color.blue, rsp_mon.best_blue);
                  bad++;
               end
               if (rsp_mon.best_distance !== want.distance) begin
                  $error("best_distance mismatch: expected %0d, actual %0d",
                         want.distance, rsp_mon.best_distance);
                  bad++;
               end
            end
         end

         // Store a write beat, or predict the answer to a query beat
         if (req_mon.valid && req_mon.ready) begin
            pixel = '{red: req_mon.red, green: req_mon.green, blue: req_mon.blue};
            if (req_mon.operation == OP_WRITE) begin
               swatch[req_mon.entry_index] = pixel;
            end else begin
               nearest_q.push_back(nearest_entry(pixel));
               query_total++;
            end
         end
      end
      bad_total      = bad_total + bad;
      mismatch_count <= bad_total;
      pending_count  <= nearest_q.size();
      query_count    <= query_total;
      answer_count   <= answer_total;
   end

endmodule

// File: tb/tb_nearest_palette_color_search.sv
// Top of the nearest palette colour search testbench: clock, reset, request and
// response traffic, size register writes, watchdog and verdict.
// Depends on npcs_pkg, npcs_if, the block itself and npcs_search_checker.
`timescale 1ns / 1ps

module tb_nearest_palette_color_search;
   import npcs_pkg::*;

   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 100;
   localparam int SCAN_SLACK  = PAL_ENTRIES + 8;
   localparam int TAIL_CYCLES = 40;
   localparam int HOLD_OFF    = 400;
   localparam int STALL_LIMIT = 4000;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   int mismatch_count;
   int pending_count;
   int query_count;
   int answer_count;
   int beats_sent;
   int responses_taken;
   int settings_used;
   int idle_cycles;

   npcs_req_if req_bus ();
   npcs_rsp_if rsp_bus ();

   nearest_palette_color_search u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   npcs_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .query_count    (query_count),
      .answer_count   (answer_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one request beat after a random gap and hold it until taken
   task automatic send_beat(input op_type op, input logic [PAL_IDX_W-1:0] idx,
                            input rgb_type color);
      int gap;
      gap = ((beats_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.entry_index <= idx;
      req_bus.red         <= color.red;
      req_bus.green       <= color.green;
      req_bus.blue        <= color.blue;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      beats_sent++;
   endtask

   // Drop valid, wait for every answer, then let a trailing scan finish
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SCAN_SLACK) @(posedge clock);
   endtask

   task automatic write_palette_size(input logic [SIZE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   // Clustered levels make duplicate entries and so distance ties
   function automatic logic [CHAN_W-1:0] pick_channel(input bit clustered);
      logic [CHAN_W-1:0] level [4];
      level = '{8'h00, 8'hFF, 8'h80, 8'h3F};
      if (clustered && $urandom_range(0, 3) != 0) return level[$urandom_range(0, 3)];
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [SIZE_W-1:0] phase_size(input int phase);
      logic [SIZE_W-1:0] fixed [7];
      fixed = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd15};
      if (phase < 7) return fixed[phase];
      return SIZE_W'($urandom_range(0, 31));
   endfunction

   // Receiver: random stalls, bursts without stalls, and long hold-offs
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (responses_taken == 150 || responses_taken == 600) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         stall = ((responses_taken / 40) % 4 == 2) ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(negedge clock); while (!rsp_bus.valid);
         @(posedge clock);
         responses_taken++;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      rgb_type color;
      bit      clustered;
      int      query_pct;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.operation   <= OP_WRITE;
      req_bus.entry_index <= '0;
      req_bus.red         <= '0;
      req_bus.green       <= '0;
      req_bus.blue        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Single-entry palette: farthest and nearest pixels
      write_palette_size(5'd1);
      send_beat(OP_WRITE, 4'd0, '{red: 8'h00, green: 8'h00, blue: 8'h00});
      send_beat(OP_QUERY, 4'd15, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
      send_beat(OP_QUERY, 4'd0, '{red: 8'h00, green: 8'h00, blue: 8'h00});

      // Size zero is searched as one entry
      quiesce();
      write_palette_size(5'd0);
      send_beat(OP_QUERY, 4'd7, '{red: 8'h80, green: 8'h80, blue: 8'h80});

      // Fill the rest of the palette: corners, a duplicate of entry zero, noise
      send_beat(OP_WRITE, 4'd1, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
      send_beat(OP_WRITE, 4'd2, '{red: 8'hFF, green: 8'h00, blue: 8'h00});
      send_beat(OP_WRITE, 4'd3, '{red: 8'h00, green: 8'hFF, blue: 8'h00});
      send_beat(OP_WRITE, 4'd4, '{red: 8'h00, green: 8'h00, blue: 8'hFF});
      send_beat(OP_WRITE, 4'd5, '{red: 8'h00, green: 8'h00, blue: 8'h00});
      for (int i = 6; i < PAL_ENTRIES; i++) begin
         color = '{red: pick_channel(1'b0), green: pick_channel(1'b0),
                   blue: pick_channel(1'b0)};
         send_beat(OP_WRITE, PAL_IDX_W'(i), color);
      end

      // Oversized setting clamps to the full palette; black ties entries 0 and 5
      quiesce();
      write_palette_size(5'd31);
      send_beat(OP_QUERY, 4'd0, '{red: 8'h00, green: 8'h00, blue: 8'h00});
      send_beat(OP_QUERY, 4'd3, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
      send_beat(OP_QUERY, 4'd9, '{red: 8'hFE, green: 8'h01, blue: 8'h00});
      send_beat(OP_QUERY, 4'd12, '{red: 8'h01, green: 8'hFF, blue: 8'h02});
      send_beat(OP_QUERY, 4'd6, '{red: 8'h00, green: 8'h02, blue: 8'hFD});
      send_beat(OP_QUERY, 4'd10, '{red: 8'h5A, green: 8'hA5, blue: 8'h3C});

      // Random phases, each under its own palette size
      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         write_palette_size(phase_size(phase));
         clustered = (phase % 3 == 1);
         query_pct = $urandom_range(40, 85);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            color = '{red: pick_channel(clustered), green: pick_channel(clustered),
                      blue: pick_channel(clustered)};
            if ($urandom_range(1, 100) <= query_pct)
               send_beat(OP_QUERY, PAL_IDX_W'($urandom_range(0, 15)), color);
            else
               send_beat(OP_WRITE, PAL_IDX_W'($urandom_range(0, 15)), color);
         end
      end

      // Drain and let the block settle
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats, %0d of them queries, and %0d responses",
               beats_sent, query_count, answer_count);
      $display("across %0d palette size settings, with two long response hold-offs",
               settings_used);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
